FILE: rtl/lrf_pkg.sv
// ----------------------------------------------------------------------------
// lrf_pkg: shared types and functions of the log record framer
// CRC32C byte step, record header byte selection, magic constant.
// ----------------------------------------------------------------------------
package lrf_pkg;

   localparam int unsigned MaxPayload = 256;
   localparam logic [31:0] CrcPoly    = 32'h82F6_3B78;
   localparam logic [31:0] CrcInit    = 32'hFFFF_FFFF;
   localparam logic [63:0] SegMagic   = 64'h0031_304C_4157_564B;
   localparam logic [8:0]  HeadLen    = 9'd28;
   localparam logic [8:0]  FrameExtra = 9'd32;
   localparam logic [4:0]  BodyOfs    = 5'd16;
   localparam logic [3:0]  MagicLen   = 4'd8;
   localparam logic        CmdHeader  = 1'b0;
   localparam logic        CmdPayload = 1'b1;

   typedef struct packed {
      logic       wr_en;
      logic [7:0] wr_addr;
      logic [7:0] wr_data;
      logic       rd_en;
      logic [7:0] rd_addr;
   } ram_req_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [7:0] hdr_byte(input logic [4:0] pos, input logic [31:0] body,
                                           input logic [31:0] tail, input logic [63:0] term,
                                           input logic [8:0] len, input logic [63:0] index);
      logic [223:0] v;
      v = {index[31:0], index[63:32], {23'd0, len}, term[31:0], term[63:32], tail, body};
      return v[{pos, 3'b000} +: 8];
   endfunction

endpackage

FILE: rtl/lrf_if.sv
// ----------------------------------------------------------------------------
// lrf_req_if / lrf_rsp_if: valid/ready channels of the log record framer
// Request carries header or payload byte items, response carries beats.
// ----------------------------------------------------------------------------
interface lrf_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [63:0] log_term;
   logic [63:0] log_index;
   logic [8:0]  payload_len;
   logic [7:0]  payload_byte;

   modport source (output valid, cmd, log_term, log_index, payload_len, payload_byte,
                   input ready);
   modport sink   (input valid, cmd, log_term, log_index, payload_len, payload_byte,
                   output ready);
endinterface

interface lrf_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] beat_data;
   logic [3:0]  beat_bytes;
   logic        segment_start;
   logic        last_beat;

   modport source (output valid, beat_data, beat_bytes, segment_start, last_beat,
                   input ready);
   modport sink   (input valid, beat_data, beat_bytes, segment_start, last_beat,
                   output ready);
endinterface

FILE: rtl/log_record_framer_crc32c_unit.sv
// ----------------------------------------------------------------------------
// log_record_framer_crc32c_unit: CRC32C framed log record emitter
// A header transfer (cmd 0) gives term, index and length; payload byte
// transfers (cmd 1) follow and are stored in the payload RAM while the body
// CRC advances one byte per transfer. Header intake seeds the body CRC over
// the length and index fields; req is low meanwhile. When the record is
// complete the block walks the frame twice through the payload RAM, one
// byte per cycle while rsp does not stall: a tail CRC pass over the header
// and payload, and an emit pass over the whole frame that packs bytes into
// 8-byte beats on rsp. req is low from the last byte until the last beat is
// in the output register. rsp stalls hold the output register and pause the
// emit pass. The segment limit register is written by csr_wr_en and
// csr_wr_data; the user must write it only while the block is idle, the
// block itself does not enforce this. Reset returns to idle, arms the
// magic for the first record and restores the default segment limit.
// ----------------------------------------------------------------------------
module log_record_framer_crc32c_unit (
   input  logic        clock,
   input  logic        reset,
   lrf_req_if.sink     req_ch,
   lrf_rsp_if.source   rsp_ch,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   localparam logic [2:0] StIdle    = 3'd0;
   localparam logic [2:0] StHdrCrc  = 3'd1;
   localparam logic [2:0] StCollect = 3'd2;
   localparam logic [2:0] StFinish  = 3'd3;
   localparam logic [2:0] StPre     = 3'd4;
   localparam logic [2:0] StTail    = 3'd5;
   localparam logic [2:0] StEmit    = 3'd6;
   localparam logic [2:0] StPost    = 3'd7;

   logic [2:0]  state_ff, state_in;
   logic [63:0] term_ff, term_in, index_ff, index_in;
   logic [8:0]  len_ff, len_in, rcv_ff, rcv_in;
   logic [31:0] bcrc_ff, bcrc_in, tail_crc_ff, tail_crc_in;
   logic [3:0]  hcnt_ff, hcnt_in;
   logic [32:0] seg_ff, seg_in;
   logic        magic_ff, magic_in, post_ff, post_in;
   logic [31:0] max_ff, max_in;
   logic [8:0]  pos_ff, pos_in, s1_pos_ff, s1_pos_in;
   logic        s1_vld_ff, s1_vld_in;
   logic [63:0] acc_data_ff, acc_data_in;
   logic [3:0]  acc_cnt_ff, acc_cnt_in;
   logic        acc_full_ff, acc_full_in, acc_last_ff, acc_last_in;
   logic        out_vld_ff, out_vld_in, out_seg_ff, out_seg_in, out_last_ff, out_last_in;
   logic [63:0] out_data_ff, out_data_in;
   logic [3:0]  out_bytes_ff, out_bytes_in;

   lrf_pkg::ram_req_type ram_req;
   logic [7:0]  rd_data;

   logic        req_take, out_free, flush, s1_take, advance;
   logic [8:0]  total, pass_end, tail_ofs, len_sat;
   logic [31:0] tail_field, tail_final;
   logic [7:0]  s1_byte;
   logic [32:0] seg_sum;
   logic [3:0]  cnt_eff;
   logic [4:0]  hdr_pos;

   lrf_payload_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   assign req_ch.ready         = (state_ff == StIdle) || (state_ff == StCollect);
   assign req_take             = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid         = out_vld_ff;
   assign rsp_ch.beat_data     = out_data_ff;
   assign rsp_ch.beat_bytes    = out_bytes_ff;
   assign rsp_ch.segment_start = out_seg_ff;
   assign rsp_ch.last_beat     = out_last_ff;
   assign out_free             = !out_vld_ff || rsp_ch.ready;

   assign total      = len_ff + lrf_pkg::FrameExtra;
   assign pass_end   = (state_ff == StEmit) ? total : (len_ff + lrf_pkg::HeadLen);
   assign tail_final = tail_crc_ff ^ lrf_pkg::CrcInit;
   assign tail_field = (state_ff == StEmit) ? tail_final : 32'd0;
   assign tail_ofs   = s1_pos_ff - lrf_pkg::HeadLen - len_ff;
   assign len_sat    = (req_ch.payload_len > 9'(lrf_pkg::MaxPayload)) ?
                       9'(lrf_pkg::MaxPayload) : req_ch.payload_len;
   assign seg_sum    = (magic_ff ? 33'(lrf_pkg::MagicLen) : seg_ff) + {24'd0, total};
   assign hdr_pos    = (state_ff == StHdrCrc) ? (lrf_pkg::BodyOfs + {1'b0, hcnt_ff})
                                              : s1_pos_ff[4:0];

   always_comb begin
      if (s1_pos_ff < lrf_pkg::HeadLen) begin
         s1_byte = lrf_pkg::hdr_byte(hdr_pos, bcrc_ff ^ lrf_pkg::CrcInit, tail_field,
                                     term_ff, len_ff, index_ff);
      end else if (s1_pos_ff < len_ff + lrf_pkg::HeadLen) begin
         s1_byte = rd_data;
      end else begin
         s1_byte = tail_final[{tail_ofs[1:0], 3'b000} +: 8];
      end
   end

   assign flush   = (state_ff == StEmit) && acc_full_ff && out_free;
   assign s1_take = s1_vld_ff && ((state_ff == StTail) || !acc_full_ff || flush);
   assign advance = ((state_ff == StTail) || (state_ff == StEmit)) &&
                    (pos_ff < pass_end) && (!s1_vld_ff || s1_take);
   assign cnt_eff = flush ? 4'd0 : acc_cnt_ff;

   always_comb begin
      state_in     = state_ff;
      term_in      = term_ff;
      index_in     = index_ff;
      len_in       = len_ff;
      rcv_in       = rcv_ff;
      bcrc_in      = bcrc_ff;
      tail_crc_in  = tail_crc_ff;
      hcnt_in      = hcnt_ff;
      seg_in       = seg_ff;
      magic_in     = magic_ff;
      post_in      = post_ff;
      max_in       = csr_wr_en ? csr_wr_data : max_ff;
      pos_in       = pos_ff;
      s1_pos_in    = s1_pos_ff;
      s1_vld_in    = s1_vld_ff;
      acc_data_in  = acc_data_ff;
      acc_cnt_in   = acc_cnt_ff;
      acc_full_in  = acc_full_ff;
      acc_last_in  = acc_last_ff;
      out_vld_in   = out_vld_ff && !rsp_ch.ready;
      out_data_in  = out_data_ff;
      out_bytes_in = out_bytes_ff;
      out_seg_in   = out_seg_ff;
      out_last_in  = out_last_ff;
      ram_req      = '0;
      ram_req.wr_addr = rcv_ff[7:0];
      ram_req.wr_data = req_ch.payload_byte;
      ram_req.rd_en   = advance;
      ram_req.rd_addr = 8'(pos_ff - lrf_pkg::HeadLen);

      if (advance) begin
         s1_vld_in = 1'b1;
         s1_pos_in = pos_ff;
         pos_in    = pos_ff + 9'd1;
      end else if (s1_take) begin
         s1_vld_in = 1'b0;
      end

      case (state_ff)
         StIdle, StCollect: begin
            if (req_take && req_ch.cmd == lrf_pkg::CmdHeader) begin
               term_in     = req_ch.log_term;
               index_in    = req_ch.log_index;
               len_in      = len_sat;
               rcv_in      = 9'd0;
               bcrc_in     = lrf_pkg::CrcInit;
               hcnt_in     = 4'd0;
               state_in    = StHdrCrc;
            end else if (req_take && state_ff == StCollect) begin
               ram_req.wr_en = 1'b1;
               bcrc_in       = lrf_pkg::crc_byte(bcrc_ff, req_ch.payload_byte);
               rcv_in        = rcv_ff + 9'd1;
               if (rcv_ff + 9'd1 == len_ff) begin
                  state_in = StFinish;
               end
            end
         end
         StHdrCrc: begin
            bcrc_in = lrf_pkg::crc_byte(bcrc_ff, lrf_pkg::hdr_byte(hdr_pos,
                         32'd0, 32'd0, term_ff, len_ff, index_ff));
            hcnt_in = hcnt_ff + 4'd1;
            if (hcnt_ff == 4'd11) begin
               state_in = (len_ff == 9'd0) ? StFinish : StCollect;
            end
         end
         StFinish: begin
            post_in     = seg_sum >= {1'b0, max_ff};
            seg_in      = (seg_sum >= {1'b0, max_ff}) ? 33'(lrf_pkg::MagicLen) : seg_sum;
            magic_in    = 1'b0;
            pos_in      = 9'd0;
            s1_vld_in   = 1'b0;
            tail_crc_in = lrf_pkg::CrcInit;
            state_in    = magic_ff ? StPre : StTail;
         end
         StPre, StPost: begin
            if (out_free) begin
               out_vld_in   = 1'b1;
               out_data_in  = lrf_pkg::SegMagic;
               out_bytes_in = lrf_pkg::MagicLen;
               out_seg_in   = 1'b1;
               out_last_in  = (state_ff == StPost);
               state_in     = (state_ff == StPost) ? StIdle : StTail;
            end
         end
         StTail: begin
            if (s1_take) begin
               tail_crc_in = lrf_pkg::crc_byte(tail_crc_ff, s1_byte);
            end
            if (pos_ff == pass_end && !s1_vld_ff) begin
               pos_in   = 9'd0;
               state_in = StEmit;
            end
         end
         StEmit: begin
            if (flush) begin
               out_vld_in   = 1'b1;
               out_data_in  = acc_data_ff;
               out_bytes_in = acc_cnt_ff;
               out_seg_in   = 1'b0;
               out_last_in  = acc_last_ff && !post_ff;
               acc_data_in  = 64'd0;
               acc_cnt_in   = 4'd0;
               acc_full_in  = 1'b0;
               acc_last_in  = 1'b0;
            end
            if (s1_take) begin
               acc_data_in = (flush ? 64'd0 : acc_data_ff) |
                             ({56'd0, s1_byte} << {cnt_eff[2:0], 3'b000});
               acc_cnt_in  = cnt_eff + 4'd1;
               acc_last_in = (s1_pos_ff == total - 9'd1);
               acc_full_in = (cnt_eff == 4'd7) || (s1_pos_ff == total - 9'd1);
            end
            if (pos_ff == pass_end && !s1_vld_ff && !acc_full_ff) begin
               state_in = post_ff ? StPost : StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= StIdle;
         seg_ff      <= 33'd0;
         magic_ff    <= 1'b1;
         max_ff      <= 32'd67108864;
         s1_vld_ff   <= 1'b0;
         pos_ff      <= 9'd0;
         acc_data_ff <= 64'd0;
         acc_cnt_ff  <= 4'd0;
         acc_full_ff <= 1'b0;
         acc_last_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         seg_ff      <= seg_in;
         magic_ff    <= magic_in;
         max_ff      <= max_in;
         s1_vld_ff   <= s1_vld_in;
         pos_ff      <= pos_in;
         acc_data_ff <= acc_data_in;
         acc_cnt_ff  <= acc_cnt_in;
         acc_full_ff <= acc_full_in;
         acc_last_ff <= acc_last_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      term_ff      <= term_in;
      index_ff     <= index_in;
      len_ff       <= len_in;
      rcv_ff       <= rcv_in;
      bcrc_ff      <= bcrc_in;
      tail_crc_ff  <= tail_crc_in;
      hcnt_ff      <= hcnt_in;
      post_ff      <= post_in;
      s1_pos_ff    <= s1_pos_in;
      out_data_ff  <= out_data_in;
      out_bytes_ff <= out_bytes_in;
      out_seg_ff   <= out_seg_in;
      out_last_ff  <= out_last_in;
   end

endmodule

FILE: rtl/lrf_payload_ram.sv
// ----------------------------------------------------------------------------
// lrf_payload_ram: payload buffer of the log record framer
// 256 x 8 synchronous memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lrf_payload_ram (
   input  logic                 clock,
   input  lrf_pkg::ram_req_type ram_req,
   output logic [7:0]           rd_data
);

   logic [7:0] mem [256];

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      if (ram_req.rd_en) begin
         rd_data <= mem[ram_req.rd_addr];
      end
   end

endmodule
